FILE: hw/rtl/adpcm_frame_decoder_core_macros.svh
// assertion macros used by the bound checker
`ifndef ADPCM_FRAME_DECODER_CORE_MACROS_SVH
`define ADPCM_FRAME_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define AFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adpcm frame decoder check failed");

// next-cycle implication, disabled while reset is held
`define AFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adpcm frame decoder check failed");

`endif

FILE: hw/rtl/afd_pkg.sv
package afd_pkg;

    localparam int FRAC_BITS = 11;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int NIB_W     = 4;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 34;
    localparam int SHIFTED_W = ACC_W - FRAC_BITS;
    localparam int BODY_W    = 64;
    localparam int TAPS      = 16;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_CONT  = 2'd1;
    localparam logic [1:0] MODE_FRESH = 2'd2;

    localparam logic [3:0] COUNT_RESET = 4'd1;
    localparam logic [3:0] LAST_SAMPLE = 4'd15;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LO,
        ST_HI
    } state_t;

    typedef struct packed {
        logic clear;
        logic lo_en;
        logic hi_en;
    } mac_ctrl_t;

    typedef struct packed {
        logic load;
        logic last;
    } out_ctrl_t;

    // clamp the scaled accumulator to a 16-bit sample
    function automatic logic signed [SAMPLE_W-1:0] sat16(
        input logic signed [SHIFTED_W-1:0] v
    );
        logic [SHIFTED_W-SAMPLE_W:0] top;
        logic signed [SAMPLE_W-1:0]  res;
        top = v[SHIFTED_W-1:SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            res = v[SAMPLE_W-1:0];
        end else if (v[SHIFTED_W-1]) begin
            res = SAT_MIN;
        end else begin
            res = SAT_MAX;
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/afd_coef_ram.sv
module afd_coef_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [AW-1:0]                       wr_addr,
    input  logic signed [afd_pkg::COEF_W-1:0]   wr_data,
    input  logic                                rd_en,
    input  logic [AW-1:0]                       rd_addr,
    output logic signed [afd_pkg::COEF_W-1:0]   rd_data
);
    import afd_pkg::*;

    logic signed [COEF_W-1:0] coef_reg [DEPTH];
    logic signed [COEF_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            coef_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= coef_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/afd_mac.sv
module afd_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  afd_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [afd_pkg::NIB_W-1:0]    nib,
    input  logic [3:0]                          shift,
    input  logic signed [afd_pkg::COEF_W-1:0]   coef,
    output logic signed [afd_pkg::SAMPLE_W-1:0] sample_next
);
    import afd_pkg::*;

    logic signed [SAMPLE_W-1:0] h1_reg, h2_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]   product;
    logic signed [ACC_W-1:0]    prod_ext, nib_ext, nib_term, lo_sum, hi_sum;
    logic [4:0]                 shamt;

    // one shared multiplier: older history on the low step, newer on the high step
    assign mul_b    = ctrl.hi_en ? h1_reg : h2_reg;
    assign product  = coef * mul_b;
    assign prod_ext = {{(ACC_W-PROD_W){product[PROD_W-1]}}, product};

    assign shamt    = {1'b0, shift} + 5'(FRAC_BITS);
    assign nib_ext  = {{(ACC_W-NIB_W){nib[NIB_W-1]}}, nib};
    assign nib_term = nib_ext <<< shamt;

    assign lo_sum = nib_term + prod_ext;
    assign hi_sum = acc_reg + prod_ext;

    assign sample_next = sat16($signed(hi_sum[ACC_W-1:FRAC_BITS]));

    always_ff @(posedge aclk) begin
        if (ctrl.lo_en) begin
            acc_reg <= lo_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_reg <= '0;
            h2_reg <= '0;
        end else if (ctrl.clear) begin
            h1_reg <= '0;
            h2_reg <= '0;
        end else if (ctrl.hi_en) begin
            h2_reg <= h1_reg;
            h1_reg <= sample_next;
        end
    end

endmodule

FILE: hw/rtl/afd_seq.sv
module afd_seq #(
    parameter int MAX_PRED = 8,
    parameter int AW       = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic                              fresh,
    input  logic [7:0]                        header,
    input  logic [afd_pkg::BODY_W-1:0]        body,
    input  logic [3:0]                        pred_count,
    input  logic                              out_free,
    output logic                              idle,
    output logic                              rd_en,
    output logic [AW-1:0]                     rd_addr,
    output afd_pkg::mac_ctrl_t                mac_ctrl,
    output logic signed [afd_pkg::NIB_W-1:0]  nib,
    output logic [3:0]                        shift,
    output afd_pkg::out_ctrl_t                out_ctrl
);
    import afd_pkg::*;

    state_t            state_reg, state_next;
    logic [3:0]        k_reg;
    logic [BODY_W-1:0] body_reg;
    logic [3:0]        shift_reg;
    logic [3:0]        pred_reg;

    logic [4:0] count_eff;
    logic       pred_ok;
    logic [3:0] k_fetch;
    logic [3:0] tap;
    logic       advance;

    // counts above the table size act as the table size
    assign count_eff = ({1'b0, pred_count} > 5'(MAX_PRED)) ? 5'(MAX_PRED)
                                                          : {1'b0, pred_count};
    assign pred_ok   = ({1'b0, header[3:0]} < count_eff);

    assign advance = (state_reg == ST_HI) && out_free;

    // coefficient for the next multiply: second tap on fetch/high, first tap on low
    assign k_fetch = (state_reg == ST_HI) ? k_reg + 4'd1 : k_reg;
    assign tap     = (state_reg == ST_LO) ? {1'b0, k_reg[2:0]} : {1'b1, k_fetch[2:0]};
    assign rd_addr = AW'({pred_reg, tap});

    assign nib   = body_reg[BODY_W-1 -: NIB_W];
    assign shift = shift_reg;
    assign idle  = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (start) begin
                k_reg <= '0;
            end else if (advance) begin
                k_reg <= k_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            body_reg  <= body;
            shift_reg <= header[7:4];
            pred_reg  <= pred_ok ? header[3:0] : 4'd0;
        end else if (advance) begin
            body_reg  <= body_reg << NIB_W;
        end
    end

    always_comb begin
        state_next     = state_reg;
        rd_en          = 1'b0;
        mac_ctrl.clear = start && fresh;
        mac_ctrl.lo_en = 1'b0;
        mac_ctrl.hi_en = 1'b0;
        out_ctrl.load  = 1'b0;
        out_ctrl.last  = (k_reg == LAST_SAMPLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                rd_en      = 1'b1;
                state_next = ST_LO;
            end
            ST_LO: begin
                rd_en          = 1'b1;
                mac_ctrl.lo_en = 1'b1;
                state_next     = ST_HI;
            end
            ST_HI: begin
                if (out_free) begin
                    rd_en          = 1'b1;
                    mac_ctrl.hi_en = 1'b1;
                    out_ctrl.load  = 1'b1;
                    state_next     = (k_reg == LAST_SAMPLE) ? ST_IDLE : ST_LO;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/adpcm_frame_decoder_core.sv
// coefficient load request: taken while idle, and the block stays ready for further requests
// frame request: after acceptance the sequencer fetches, then runs a low and a high step per sample,
// a two-step multiply-add on one shared multiplier; each sample is registered at its high step
// a stalled result register holds the sequencer in place until the sample is taken
// reset (synchronous, active low) clears history to zero and predictor count to 1;
// the coefficient table is not cleared and holds whatever was last written
module adpcm_frame_decoder_core #(
    parameter int MAX_PREDICTORS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: predictor count
    input  logic                                cfg_wr_en,
    input  logic [3:0]                          cfg_wr_data,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_mode,
    input  logic [6:0]                          s_coef_slot,
    input  logic signed [afd_pkg::COEF_W-1:0]   s_coef_value,
    input  logic [7:0]                          s_frame_header,
    input  logic [afd_pkg::BODY_W-1:0]          s_frame_body,
    // sample channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [afd_pkg::SAMPLE_W-1:0] m_sample,
    output logic                                m_last_of_frame
);
    import afd_pkg::*;

    // sixteen taps per predictor: first half weights the newer sample
    localparam int DEPTH = MAX_PREDICTORS * TAPS;
    localparam int AW    = $clog2(DEPTH);

    logic [3:0] count_reg;

    logic                        accept;
    logic                        slot_ok;
    logic                        wr_en;
    logic                        start;
    logic                        fresh;
    logic                        seq_idle;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic signed [COEF_W-1:0]    rd_coef;
    mac_ctrl_t                   mac_ctrl;
    out_ctrl_t                   out_ctrl;
    logic signed [NIB_W-1:0]     nib;
    logic [3:0]                  shift;
    logic signed [SAMPLE_W-1:0]  sample_next;
    logic                        out_free;

    logic                        m_valid_reg;
    logic signed [SAMPLE_W-1:0]  m_sample_reg;
    logic                        m_last_reg;

    // predictor count register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // requests are only taken between frames
    assign s_ready = seq_idle;
    assign accept  = s_valid && s_ready;

    // writes beyond the table are dropped; the unused mode is ignored entirely
    assign slot_ok = (9'(s_coef_slot) < 9'(DEPTH));
    assign wr_en   = accept && (s_mode == MODE_LOAD) && slot_ok;
    assign start   = accept && ((s_mode == MODE_CONT) || (s_mode == MODE_FRESH));
    assign fresh   = (s_mode == MODE_FRESH);

    // the result register frees up when empty or when its sample is taken this cycle
    assign out_free = !m_valid_reg || m_ready;

    afd_coef_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_coef_slot)),
        .wr_data (s_coef_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_coef)
    );

    afd_seq #(
        .MAX_PRED (MAX_PREDICTORS),
        .AW       (AW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .fresh      (fresh),
        .header     (s_frame_header),
        .body       (s_frame_body),
        .pred_count (count_reg),
        .out_free   (out_free),
        .idle       (seq_idle),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .mac_ctrl   (mac_ctrl),
        .nib        (nib),
        .shift      (shift),
        .out_ctrl   (out_ctrl)
    );

    // shared multiply-add: low step nibble term plus older product, high step adds newer
    afd_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (mac_ctrl),
        .nib         (nib),
        .shift       (shift),
        .coef        (rd_coef),
        .sample_next (sample_next)
    );

    // result register parts the output handshake from the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ctrl.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ctrl.load) begin
            m_sample_reg <= sample_next;
            m_last_reg   <= out_ctrl.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample        = m_sample_reg;
    assign m_last_of_frame = m_last_reg;

endmodule

FILE: hw/rtl/afd_checker.sv
`include "adpcm_frame_decoder_core_macros.svh"

module afd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [1:0]                          s_mode,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [afd_pkg::SAMPLE_W-1:0] m_sample,
    input logic                                m_last_of_frame
);
    import afd_pkg::*;

    // a sample waiting on the consumer holds still
    `AFD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample) && $stable(m_last_of_frame))

    // a frame request makes the block busy on the next cycle
    `AFD_ASSERT_NXT(a_busy_after_frame, aclk, aresetn, s_valid && s_ready && (s_mode == MODE_CONT || s_mode == MODE_FRESH), !s_ready)

    // a coefficient load does not hold up the next request
    `AFD_ASSERT_NXT(a_load_single_cycle, aclk, aresetn, s_valid && s_ready && s_mode == MODE_LOAD, s_ready)

    // no new sample appears straight out of idle
    `AFD_ASSERT_NXT(a_no_sample_from_idle, aclk, aresetn, s_ready, !$rose(m_valid))

endmodule

bind adpcm_frame_decoder_core afd_checker u_afd_checker (.*);

FILE: sim/afd_sample_checker.sv
module afd_sample_checker #(
    parameter int MAX_PREDICTORS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [3:0]                          cfg_wr_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_mode,
    input  logic [6:0]                          s_coef_slot,
    input  logic signed [afd_pkg::COEF_W-1:0]   s_coef_value,
    input  logic [7:0]                          s_frame_header,
    input  logic [afd_pkg::BODY_W-1:0]          s_frame_body,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [afd_pkg::SAMPLE_W-1:0] m_sample,
    input  logic                                m_last_of_frame,
    output int                                  fail_count,
    output int                                  pending_samples,
    output int                                  frames_decoded,
    output int                                  coefs_loaded,
    output int                                  samples_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import afd_pkg::*;

    localparam int BOOK_DEPTH = MAX_PREDICTORS * TAPS;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } pcm_result_t;

    logic signed [COEF_W-1:0]   coef_book [BOOK_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_last;
    logic signed [SAMPLE_W-1:0] hist_prev;
    logic [3:0]                 pred_limit;
    pcm_result_t                expected_pcm [$];
    pcm_result_t                want;

    // two-tap recurrence over the sixteen nibbles of one frame
    task automatic predict_frame(input logic [7:0] header, input logic [BODY_W-1:0] body);
        int unsigned               lim;
        int unsigned               sel;
        int unsigned               base;
        longint                    h1;
        longint                    h2;
        longint                    acc;
        longint                    s;
        logic signed [NIB_W-1:0]   nib;
        pcm_result_t               r;
        lim  = (pred_limit > MAX_PREDICTORS) ? MAX_PREDICTORS : pred_limit;
        sel  = header[3:0];
        if (sel >= lim) begin
            sel = 0;
        end
        base = sel * TAPS;
        h1   = hist_last;
        h2   = hist_prev;
        for (int k = 0; k < TAPS; k++) begin
            nib = body[BODY_W-1-NIB_W*k -: NIB_W];
            acc = (longint'(nib) <<< (header[7:4] + FRAC_BITS))
                + longint'(coef_book[base + (k % 8)]) * h1
                + longint'(coef_book[base + (k % 8) + 8]) * h2;
            s = acc >>> FRAC_BITS;
            if (s > SAT_MAX) begin
                s = SAT_MAX;
            end else if (s < SAT_MIN) begin
                s = SAT_MIN;
            end
            r.sample = s[SAMPLE_W-1:0];
            r.last   = (k == TAPS - 1);
            expected_pcm.push_back(r);
            h2 = h1;
            h1 = s;
        end
        hist_last = h1[SAMPLE_W-1:0];
        hist_prev = h2[SAMPLE_W-1:0];
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            hist_last  = '0;
            hist_prev  = '0;
            pred_limit = COUNT_RESET;
            expected_pcm.delete();
        end else begin
            if (cfg_wr_en) begin
                pred_limit = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                case (s_mode)
                    MODE_LOAD: begin
                        if (s_coef_slot < BOOK_DEPTH) begin
                            coef_book[s_coef_slot] = s_coef_value;
                        end
                        coefs_loaded++;
                    end
                    MODE_CONT, MODE_FRESH: begin
                        if (s_mode == MODE_FRESH) begin
                            hist_last = '0;
                            hist_prev = '0;
                        end
                        predict_frame(s_frame_header, s_frame_body);
                        frames_decoded++;
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_pcm.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected sample %0d last %0b", m_sample, m_last_of_frame);
                    end
                end else begin
                    want = expected_pcm.pop_front();
                    samples_checked++;
                    if (want.sample !== m_sample || want.last !== m_last_of_frame) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("sample mismatch: expected %0d last %0b, got %0d last %0b",
                                     want.sample, want.last, m_sample, m_last_of_frame);
                        end
                    end
                end
            end
        end
        pending_samples = expected_pcm.size();
    end

endmodule

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import afd_pkg::*;

    localparam int         MAX_PREDICTORS = 8;
    // a frame keeps the block busy until its last sample is loaded
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         PHASE_ITEMS    = 44;
    // the unused mode code, which the block ignores
    localparam logic [1:0] MODE_NOP       = 2'd3;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [3:0]                 cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_mode;
    logic [6:0]                 s_coef_slot;
    logic signed [COEF_W-1:0]   s_coef_value;
    logic [7:0]                 s_frame_header;
    logic [BODY_W-1:0]          s_frame_body;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample;
    logic                       m_last_of_frame;

    // stimulus-side bookkeeping: which coefficient words hold a value, and the count in force
    logic [MAX_PREDICTORS*TAPS-1:0] book_written;
    logic [3:0]                     count_setting;
    logic [3:0]                     random_count;
    bit                             quiet_run;

    int fail_count;
    int pending_samples;
    int frames_decoded;
    int coefs_loaded;
    int samples_checked;

    adpcm_frame_decoder_core #(
        .MAX_PREDICTORS (MAX_PREDICTORS)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_coef_slot     (s_coef_slot),
        .s_coef_value    (s_coef_value),
        .s_frame_header  (s_frame_header),
        .s_frame_body    (s_frame_body),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .m_last_of_frame (m_last_of_frame)
    );

    // watches both channels, keeps its own copy of the decoder state and scores every sample
    afd_sample_checker #(
        .MAX_PREDICTORS (MAX_PREDICTORS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_coef_slot     (s_coef_slot),
        .s_coef_value    (s_coef_value),
        .s_frame_header  (s_frame_header),
        .s_frame_body    (s_frame_body),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .m_last_of_frame (m_last_of_frame),
        .fail_count      (fail_count),
        .pending_samples (pending_samples),
        .frames_decoded  (frames_decoded),
        .coefs_loaded    (coefs_loaded),
        .samples_checked (samples_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #10ms;
        $display("adpcm_frame_decoder_core verification failed");
        $finish;
    end

    // sample sink: ready drops in random bursts, none once the quiet stretch starts
    initial begin : sample_sink
        int stall_left;
        m_ready    = 1'b1;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    m_ready <= 1'b1;
                end
            end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19);
                m_ready <= 1'b0;
            end
        end
    end

    // coefficient words: realistic q11 gains, fully random words, sometimes the 16-bit extremes
    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2, 3, 4: return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // one request; entered and left just after a falling edge
    task automatic issue_request(input logic [1:0] mode, input logic [6:0] slot,
                                 input logic signed [COEF_W-1:0] value,
                                 input logic [7:0] header, input logic [BODY_W-1:0] body);
        int gap;
        if (!quiet_run && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_coef_slot    <= slot;
        s_coef_value   <= value;
        s_frame_header <= header;
        s_frame_body   <= body;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // refill all sixteen taps of one predictor, unused frame fields random
    task automatic load_predictor(input int unsigned pred);
        for (int t = 0; t < TAPS; t++) begin
            issue_request(MODE_LOAD, 7'(pred * TAPS + t), rand_coef(), 8'($urandom),
                          {$urandom, $urandom});
        end
        book_written[pred*TAPS +: TAPS] = '1;
    endtask

    // hold requests back until every sample is out and the sequencer has gone quiet
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_samples != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // predictor count only changes with the block idle
    task automatic set_predictor_count(input logic [3:0] count);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        count_setting = count;
    endtask

    initial begin : stimulus
        int          done;
        int          pick;
        int unsigned lim;
        int unsigned sel;
        logic [7:0]  hdr;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_mode         = MODE_LOAD;
        s_coef_slot    = '0;
        s_coef_value   = '0;
        s_frame_header = '0;
        s_frame_body   = '0;
        book_written   = '0;
        count_setting  = COUNT_RESET;
        random_count   = '0;
        quiet_run      = 1'b0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        // predictor 0 first: it is the fallback for any out-of-range index,
        // so it must hold a full set before the first frame; tap extremes on 0 and 8
        for (int t = 0; t < TAPS; t++) begin
            issue_request(MODE_LOAD, 7'(t),
                          (t == 0) ? SAT_MAX : (t == 8) ? SAT_MIN : rand_coef(),
                          8'($urandom), {$urandom, $urandom});
        end
        book_written[TAPS-1:0] = '1;

        // zero body from cleared history gives silence
        issue_request(MODE_FRESH, '0, '0, 8'h00, '0);
        // largest shift with largest positive nibbles: clips high
        issue_request(MODE_FRESH, '0, '0, 8'hF0, 64'h7777_7777_7777_7777);
        // most negative nibbles continuing that history: clips low
        issue_request(MODE_CONT, '0, '0, 8'hF0, 64'h8888_8888_8888_8888);
        // index 15 and index 1 are both beyond a count of 1, so both fall back
        issue_request(MODE_FRESH, 7'h7F, SAT_MIN, 8'h4F, 64'h0123_4567_89AB_CDEF);
        issue_request(MODE_CONT, 7'h55, SAT_MAX, 8'h21, {$urandom, $urandom});
        // unused mode code leaves state untouched
        issue_request(MODE_NOP, 7'($urandom), 16'($urandom), 8'($urandom), {$urandom, $urandom});
        // top slot of the table, with the frame fields set
        issue_request(MODE_LOAD, 7'h7F, 16'sh1234, 8'hFF, '1);
        issue_request(MODE_CONT, 7'($urandom), 16'($urandom), 8'h30, {$urandom, $urandom});

        // ---- random part, one phase per predictor count ----
        // count 0 sends every index to predictor 0, 15 is beyond the table, 8 fills it
        for (int phase = 0; phase < 4; phase++) begin
            random_count = 4'($urandom_range(2, 7));
            case (phase)
                0:       set_predictor_count(4'd0);
                1:       set_predictor_count(4'd15);
                2:       set_predictor_count(4'd8);
                default: set_predictor_count(random_count);
            endcase
            // last stretch runs with no idling on either side
            quiet_run = (phase == 3);
            done      = 0;
            while (done < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    issue_request(MODE_NOP, 7'($urandom), 16'($urandom), 8'($urandom),
                                  {$urandom, $urandom});
                end else if (pick < 16) begin
                    // stray single-word write anywhere in the book
                    sel = $urandom_range(0, MAX_PREDICTORS * TAPS - 1);
                    issue_request(MODE_LOAD, 7'(sel), rand_coef(), 8'($urandom),
                                  {$urandom, $urandom});
                    book_written[sel] = 1'b1;
                    done++;
                end else if (pick < 22) begin
                    load_predictor($urandom_range(0, MAX_PREDICTORS - 1));
                    done += TAPS;
                end else begin
                    // frame: small shifts more often so history does not just clip
                    hdr[7:4] = $urandom_range(0, 1) ? 4'($urandom_range(0, 4))
                                                    : 4'($urandom_range(0, 15));
                    hdr[3:0] = 4'($urandom_range(0, 15));
                    lim = (count_setting > MAX_PREDICTORS) ? MAX_PREDICTORS : count_setting;
                    sel = (hdr[3:0] >= lim) ? 0 : hdr[3:0];
                    // never let a frame read a coefficient word that was not written
                    if (!(&book_written[sel*TAPS +: TAPS])) begin
                        load_predictor(sel);
                        done += TAPS;
                    end
                    issue_request(($urandom_range(0, 3) == 0) ? MODE_FRESH : MODE_CONT,
                                  7'($urandom), 16'($urandom), hdr, {$urandom, $urandom});
                    done++;
                end
            end
        end

        wait_drained();
        $display("covered %0d frame requests and %0d coefficient loads, %0d samples compared",
                 frames_decoded, coefs_loaded, samples_checked);
        $display("predictor counts 1, 0, 15, 8 and %0d, with and without idling on both sides",
                 random_count);
        if (fail_count == 0) begin
            $display("adpcm_frame_decoder_core verification clean");
        end else begin
            $display("adpcm_frame_decoder_core verification failed");
        end
        $finish;
    end

endmodule

FILE: adpcm_frame_decoder_core.f
+incdir+hw/rtl
hw/rtl/afd_pkg.sv
hw/rtl/afd_coef_ram.sv
hw/rtl/afd_mac.sv
hw/rtl/afd_seq.sv
hw/rtl/adpcm_frame_decoder_core.sv
hw/rtl/afd_checker.sv
sim/afd_sample_checker.sv
sim/tb_top.sv
